// ===== rtl/circular_deque_assert.svh =====
// assertion macros for the deque; clk and rst are taken from the module that uses them
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CDQ_ASSERT_IMP(lbl, ante, cons, msg)
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRAVERSE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } cdq_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } cdq_result_t;

endpackage

`default_nettype wire

// ===== rtl/cdq_ram.sv =====
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/circular_deque.sv =====
// Bounded double-ended queue of signed 32-bit values in a single ring memory with one
// write and one registered read port. An item is taken when start is high and busy is
// low; every result appears for exactly one cycle with strobe high, in the cycle after
// the step that produces it, and the receiver cannot stall. Pushes, and pops or
// traversals of an empty queue, complete in S_IDLE, so such items can be issued back to
// back. A pop of a held value passes through S_POP to wait for the registered memory
// read. A traversal of the held values stays in S_WALK and emits one value per cycle
// from the read port. Unknown kinds are taken in S_IDLE and give no result.
`default_nettype none

module circular_deque #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire cdq_pkg::cdq_item_t item,
  output logic                    strobe,
  output cdq_pkg::cdq_result_t    result
);

`include "circular_deque_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        walk_addr, walk_addr_next;
  logic [AW-1:0]        walk_off, walk_off_next;
  logic                 strobe_next;
  cdq_pkg::cdq_result_t result_next;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;
  logic [cdq_pkg::VALUE_W-1:0]  rdata;

  logic [AW-1:0] head_dec, head_inc, walk_inc, back_addr, tail_addr;
  logic [SW-1:0] back_sum, tail_sum;
  logic          full, empty, walk_last;

  cdq_ram #(
    .WIDTH (cdq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ring index arithmetic, one compare-subtract for the wrap
  always_comb begin
    head_dec  = (head == '0) ? LAST_IDX : head - AW'(1);
    head_inc  = (head == LAST_IDX) ? '0 : head + AW'(1);
    walk_inc  = (walk_addr == LAST_IDX) ? '0 : walk_addr + AW'(1);
    back_sum  = SW'(head) + SW'(count);
    tail_sum  = back_sum - SW'(1);
    back_addr = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
    tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    full      = (count == DEPTH_C);
    empty     = (count == '0);
    walk_last = ((CW'(walk_off) + CW'(1)) == count);
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    walk_addr_next = walk_addr;
    walk_off_next  = walk_off;
    strobe_next    = 1'b0;
    result_next    = result;
    we             = 1'b0;
    waddr          = head;
    raddr          = head;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.value_res = '0;
          result_next.status    = cdq_pkg::ST_OK;
          result_next.last      = 1'b1;
          case (item.kind) inside
            cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
              strobe_next = 1'b1;
              if (full) begin
                result_next.status = cdq_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
                if (item.kind == cdq_pkg::KIND_PUSH_FRONT) begin
                  waddr     = head_dec;
                  head_next = head_dec;
                end else begin
                  waddr = back_addr;
                end
              end
            end
            cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
              if (empty) begin
                strobe_next        = 1'b1;
                result_next.status = cdq_pkg::ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                state_next = S_POP;
                if (item.kind == cdq_pkg::KIND_POP_FRONT) begin
                  raddr     = head;
                  head_next = head_inc;
                end else begin
                  raddr = tail_addr;
                end
              end
            end
            cdq_pkg::KIND_TRAVERSE: begin
              if (empty) begin
                strobe_next        = 1'b1;
                result_next.status = cdq_pkg::ST_EMPTY;
              end else begin
                raddr          = head;
                walk_addr_next = head;
                walk_off_next  = '0;
                state_next     = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        strobe_next           = 1'b1;
        result_next.value_res = rdata;
        result_next.status    = cdq_pkg::ST_OK;
        result_next.last      = 1'b1;
        state_next            = S_IDLE;
      end
      S_WALK: begin
        // rdata holds the entry at walk_addr; fetch the one after it meanwhile
        strobe_next           = 1'b1;
        result_next.value_res = rdata;
        result_next.status    = cdq_pkg::ST_OK;
        result_next.last      = walk_last;
        raddr                 = walk_inc;
        walk_addr_next        = walk_inc;
        if (walk_last) begin
          state_next = S_IDLE;
        end else begin
          walk_off_next = walk_off + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
    walk_addr <= walk_addr_next;
    walk_off  <= walk_off_next;
    result    <= result_next;
  end

  `CDQ_ASSERT_IMP(a_count_bound, 1'b1, count <= DEPTH_C, "element count above depth")
  `CDQ_ASSERT_IMP(a_head_bound, 1'b1, head <= LAST_IDX, "head index out of ring")
  `CDQ_ASSERT_NXT(a_pop_empty, start && !busy && count == '0 && (item.kind == cdq_pkg::KIND_POP_FRONT || item.kind == cdq_pkg::KIND_POP_BACK), strobe && result.last && result.status == cdq_pkg::ST_EMPTY, "pop of empty queue not flagged")
  `CDQ_ASSERT_NXT(a_walk_cont, strobe && !result.last, strobe && result.status == cdq_pkg::ST_OK, "traversal beat stream broken")

endmodule

`default_nettype wire
